// ===== rtl/rpi_pkg.sv =====
// Shared types and constants of the RSSI proximity indicator.
package rpi_pkg;

    localparam int PCT_W  = 7;
    localparam int FREQ_W = 11;
    localparam int CNT_W  = 4;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam int RSSI_FLOOR_DBM = -110;
    localparam int RSSI_CEIL_DBM  = -30;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [FREQ_W-1:0] TONE_BASE_HZ = 11'd200;
    localparam logic [FREQ_W-1:0] TONE_STEP_HZ = 11'd18;
    localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;
    localparam int TREND_STEP = 3;
    localparam int HEAT_HOT  = 20;
    localparam int HEAT_WARM = 12;
    localparam int HEAT_NEAR = 6;

    localparam logic OP_READING    = 1'b0;
    localparam logic OP_PEAK_RESET = 1'b1;

    localparam logic REG_AUDIO_ENABLE  = 1'b0;
    localparam logic REG_BASELINE_WAIT = 1'b1;

    localparam logic [CNT_W-1:0] BASELINE_WAIT_RESET = 4'd5;

    localparam logic [1:0] TREND_STEADY = 2'd0;
    localparam logic [1:0] TREND_UP     = 2'd1;
    localparam logic [1:0] TREND_DOWN   = 2'd2;

    localparam logic [2:0] HEAT_CALIBRATING = 3'd0;
    localparam logic [2:0] HEAT_COLD_CLASS  = 3'd1;
    localparam logic [2:0] HEAT_COOL_CLASS  = 3'd2;
    localparam logic [2:0] HEAT_NEAR_CLASS  = 3'd3;
    localparam logic [2:0] HEAT_WARM_CLASS  = 3'd4;
    localparam logic [2:0] HEAT_HOT_CLASS   = 3'd5;

    localparam logic [1:0] COLOR_GREY   = 2'd0;
    localparam logic [1:0] COLOR_GREEN  = 2'd1;
    localparam logic [1:0] COLOR_YELLOW = 2'd2;
    localparam logic [1:0] COLOR_RED    = 2'd3;

    localparam logic [1:0] BAR_BLANK = 2'd0;
    localparam logic [1:0] BAR_LOW   = 2'd1;
    localparam logic [1:0] BAR_MID   = 2'd2;
    localparam logic [1:0] BAR_TALL  = 2'd3;

    localparam logic [CNT_W-1:0] BEEP_EVERY_1  = 4'd1;
    localparam logic [CNT_W-1:0] BEEP_EVERY_2  = 4'd2;
    localparam logic [CNT_W-1:0] BEEP_EVERY_5  = 4'd5;
    localparam logic [CNT_W-1:0] BEEP_EVERY_10 = 4'd10;

    typedef struct packed {
        logic             audio_enable;
        logic [CNT_W-1:0] baseline_wait;
    } rpi_cfg_t;

    typedef struct packed {
        logic [PCT_W-1:0]  pct;
        logic [1:0]        color;
        logic [1:0]        bar;
        logic [FREQ_W-1:0] tone;
    } rpi_strength_t;

    typedef struct packed {
        logic [PCT_W-1:0]  strength_pct;
        logic [1:0]        trend;
        logic [2:0]        heat_class;
        logic [1:0]        color_class;
        logic [1:0]        bar_level;
        logic              beep_fire;
        logic [FREQ_W-1:0] beep_freq_hz;
    } rpi_result_t;

endpackage

// ===== rtl/rpi_strength.sv =====
// Maps a reading to strength percent, color class, bar level and beep tone.
module rpi_strength
    import rpi_pkg::*;
#(
    parameter int RSSI_BITS = 8
)
(
    input  logic signed [RSSI_BITS-1:0] rssi,
    output rpi_strength_t               strength
);

    logic signed [RSSI_BITS:0] offset;
    logic [PCT_W-1:0]          span;
    logic [8:0]                scaled;
    logic [PCT_W-1:0]          pct;

    // Inside the window the offset is 1..79, and offset*100/80 is offset*5/4.
    assign offset = {rssi[RSSI_BITS-1], rssi} - (RSSI_BITS+1)'(RSSI_FLOOR_DBM);
    assign span   = offset[PCT_W-1:0];
    assign scaled = 9'(span) * 9'd5;

    always_comb
    begin
        if (rssi <= RSSI_FLOOR_DBM)
        begin
            pct = '0;
        end
        else if (rssi >= RSSI_CEIL_DBM)
        begin
            pct = PCT_FULL;
        end
        else
        begin
            pct = scaled[8:2];
        end
    end

    always_comb
    begin
        strength.pct  = pct;
        strength.tone = TONE_BASE_HZ + FREQ_W'(pct) * TONE_STEP_HZ;
        if (pct >= 7'd75)
        begin
            strength.color = COLOR_RED;
        end
        else if (pct >= 7'd50)
        begin
            strength.color = COLOR_YELLOW;
        end
        else if (pct >= 7'd25)
        begin
            strength.color = COLOR_GREEN;
        end
        else
        begin
            strength.color = COLOR_GREY;
        end
        if (pct >= 7'd67)
        begin
            strength.bar = BAR_TALL;
        end
        else if (pct >= 7'd34)
        begin
            strength.bar = BAR_MID;
        end
        else if (pct >= 7'd10)
        begin
            strength.bar = BAR_LOW;
        end
        else
        begin
            strength.bar = BAR_BLANK;
        end
    end

endmodule

// ===== rtl/rpi_track.sv =====
// Tracking state (readings, peak, baseline, counters) and the per-beat result.
module rpi_track
    import rpi_pkg::*;
#(
    parameter int RSSI_BITS = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        operation,
    input  logic signed [RSSI_BITS-1:0] rssi,
    input  rpi_cfg_t                    cfg,
    output rpi_result_t                 result,
    output logic signed [RSSI_BITS-1:0] peak
);

    logic signed [RSSI_BITS-1:0] previous_reg, previous_next;
    logic signed [RSSI_BITS-1:0] current_reg, current_next;
    logic signed [RSSI_BITS-1:0] peak_reg, peak_next;
    logic signed [RSSI_BITS-1:0] baseline_reg, baseline_next;
    logic                        baseline_valid_reg, baseline_valid_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            beep_reg, beep_next;
    logic [CNT_W-1:0]            beep_inc;
    logic [CNT_W-1:0]            interval;
    logic                        fire;
    logic signed [RSSI_BITS:0]   delta;
    logic signed [RSSI_BITS:0]   above;
    rpi_strength_t               strength;

    rpi_strength #(
        .RSSI_BITS (RSSI_BITS)
    ) u_strength (
        .rssi     (current_next),
        .strength (strength)
    );

    always_comb
    begin
        previous_next       = previous_reg;
        current_next        = current_reg;
        peak_next           = peak_reg;
        baseline_next       = baseline_reg;
        baseline_valid_next = baseline_valid_reg;
        count_next          = count_reg;
        if (operation == OP_PEAK_RESET)
        begin
            peak_next           = current_reg;
            baseline_valid_next = 1'b0;
        end
        else
        begin
            previous_next = current_reg;
            current_next  = rssi;
            if (count_reg < COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
            if (!baseline_valid_reg && count_next >= cfg.baseline_wait)
            begin
                baseline_next       = rssi;
                baseline_valid_next = 1'b1;
            end
            if (rssi > peak_reg)
            begin
                peak_next = rssi;
            end
        end
    end

    always_comb
    begin
        if (strength.pct >= 7'd80)
        begin
            interval = BEEP_EVERY_1;
        end
        else if (strength.pct >= 7'd50)
        begin
            interval = BEEP_EVERY_2;
        end
        else if (strength.pct >= 7'd20)
        begin
            interval = BEEP_EVERY_5;
        end
        else
        begin
            interval = BEEP_EVERY_10;
        end
        beep_inc  = beep_reg + 1'b1;
        beep_next = beep_reg;
        fire      = 1'b0;
        if (operation == OP_READING && cfg.audio_enable && baseline_valid_next)
        begin
            beep_next = beep_inc;
            if (beep_inc >= interval)
            begin
                beep_next = '0;
                fire      = 1'b1;
            end
        end
    end

    assign delta = {current_next[RSSI_BITS-1], current_next}
                 - {previous_next[RSSI_BITS-1], previous_next};
    assign above = {current_next[RSSI_BITS-1], current_next}
                 - {baseline_next[RSSI_BITS-1], baseline_next};

    always_comb
    begin
        result.strength_pct = strength.pct;
        result.color_class  = strength.color;
        result.bar_level    = strength.bar;
        result.beep_fire    = fire;
        result.beep_freq_hz = fire ? strength.tone : '0;
        if (delta > TREND_STEP)
        begin
            result.trend = TREND_UP;
        end
        else if (delta < -TREND_STEP)
        begin
            result.trend = TREND_DOWN;
        end
        else
        begin
            result.trend = TREND_STEADY;
        end
        if (!baseline_valid_next)
        begin
            result.heat_class = HEAT_CALIBRATING;
        end
        else if (above >= HEAT_HOT)
        begin
            result.heat_class = HEAT_HOT_CLASS;
        end
        else if (above >= HEAT_WARM)
        begin
            result.heat_class = HEAT_WARM_CLASS;
        end
        else if (above >= HEAT_NEAR)
        begin
            result.heat_class = HEAT_NEAR_CLASS;
        end
        else if (above >= 0)
        begin
            result.heat_class = HEAT_COOL_CLASS;
        end
        else
        begin
            result.heat_class = HEAT_COLD_CLASS;
        end
    end

    assign peak = peak_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_reg       <= '0;
            current_reg        <= '0;
            peak_reg           <= {1'b1, {(RSSI_BITS-1){1'b0}}};
            baseline_reg       <= '0;
            baseline_valid_reg <= 1'b0;
            count_reg          <= '0;
            beep_reg           <= '0;
        end
        else if (step)
        begin
            previous_reg       <= previous_next;
            current_reg        <= current_next;
            peak_reg           <= peak_next;
            baseline_reg       <= baseline_next;
            baseline_valid_reg <= baseline_valid_next;
            count_reg          <= count_next;
            beep_reg           <= beep_next;
        end
    end

endmodule

// ===== rtl/rssi_proximity_indicator_core.sv =====
// Top level of the RSSI proximity indicator: input and result registers, config port.
//
//  Channel  | Handshake              | Beat contents
//  ---------+------------------------+-----------------------------------------------
//  in       | in_valid / in_stall    | operation, rssi_dbm
//  out      | out_valid / out_stall  | strength_pct, peak_dbm, trend, heat_class,
//           |                        | color_class, bar_level, beep_fire, beep_freq_hz
//  config   | APB write, pready high | audio_enable at 0x0, baseline_wait at 0x4
//
// A beat accepted at the input waits in the input register, then moves on to the result register.
// One beat is taken every cycle when the output is not stalled.
// The tracking state updates as a beat moves from the input register to the result register.
// A stall on the output while out_valid is high holds the result register, and the input
// stalls in the same cycle whenever the input register also holds a beat.
// Reset clears all tracking state; the peak resets to the most negative reading.
module rssi_proximity_indicator_core
    import rpi_pkg::*;
#(
    parameter int RSSI_BITS = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [DATA_W-1:0]           pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic signed [RSSI_BITS-1:0] rssi_dbm,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [PCT_W-1:0]            strength_pct,
    output logic signed [RSSI_BITS-1:0] peak_dbm,
    output logic [1:0]                  trend,
    output logic [2:0]                  heat_class,
    output logic [1:0]                  color_class,
    output logic [1:0]                  bar_level,
    output logic                        beep_fire,
    output logic [FREQ_W-1:0]           beep_freq_hz
);

    rpi_cfg_t                    cfg_reg;
    logic                        in_valid_reg;
    logic                        operation_reg;
    logic signed [RSSI_BITS-1:0] rssi_reg;
    logic                        out_valid_reg;
    rpi_result_t                 result_reg;
    logic signed [RSSI_BITS-1:0] peak_reg;
    rpi_result_t                 result;
    logic signed [RSSI_BITS-1:0] peak;
    logic                        advance;
    logic                        step;

    assign pready   = 1'b1;
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.audio_enable  <= 1'b0;
            cfg_reg.baseline_wait <= BASELINE_WAIT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_AUDIO_ENABLE:  cfg_reg.audio_enable  <= pwdata[0];
                REG_BASELINE_WAIT: cfg_reg.baseline_wait <= pwdata[CNT_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_AUDIO_ENABLE:  prdata = DATA_W'(cfg_reg.audio_enable);
            REG_BASELINE_WAIT: prdata = DATA_W'(cfg_reg.baseline_wait);
            default:           prdata = '0;
        endcase
    end

    rpi_track #(
        .RSSI_BITS (RSSI_BITS)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .operation (operation_reg),
        .rssi      (rssi_reg),
        .cfg       (cfg_reg),
        .result    (result),
        .peak      (peak)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            operation_reg <= operation;
            rssi_reg      <= rssi_dbm;
        end
        if (step)
        begin
            result_reg <= result;
            peak_reg   <= peak;
        end
    end

    assign out_valid    = out_valid_reg;
    assign strength_pct = result_reg.strength_pct;
    assign peak_dbm     = peak_reg;
    assign trend        = result_reg.trend;
    assign heat_class   = result_reg.heat_class;
    assign color_class  = result_reg.color_class;
    assign bar_level    = result_reg.bar_level;
    assign beep_fire    = result_reg.beep_fire;
    assign beep_freq_hz = result_reg.beep_freq_hz;

endmodule

// ===== tb/sv/tb_rssi_proximity_indicator_core.sv =====
// Self-checking testbench for the RSSI proximity indicator core.
module tb_rssi_proximity_indicator_core;
    import rpi_pkg::*;

    localparam int RSSI_W = 8;
    localparam int DIRECTED_ROWS = 25;
    localparam int AUDIO_ROW = 13;
    localparam int PHASES = 6;
    localparam int PHASE_BEATS = 112;
    localparam int PRESSURE_PHASE = 3;
    localparam int HOLD_CYCLES = 60;
    localparam int TRACK_DEPTH = 1024;

    typedef struct packed {
        logic [PCT_W-1:0]  strength_pct;
        logic [RSSI_W-1:0] peak_dbm;
        logic [1:0]        trend;
        logic [2:0]        heat_class;
        logic [1:0]        color_class;
        logic [1:0]        bar_level;
        logic              beep_fire;
        logic [FREQ_W-1:0] beep_freq_hz;
    } readout_t;

    typedef struct packed {
        logic              op;
        logic [RSSI_W-1:0] dbm;
        logic              typed;
        readout_t          want;
    } step_t;

    localparam step_t DIRECTED_STEPS [DIRECTED_ROWS] = '{
        '{OP_READING, 8'(-128), 1'b1, '{7'd0, 8'(-128), TREND_DOWN, HEAT_CALIBRATING,
            COLOR_GREY, BAR_BLANK, 1'b0, 11'd0}},
        '{OP_READING, 8'(127), 1'b1, '{7'd100, 8'(127), TREND_UP, HEAT_CALIBRATING,
            COLOR_RED, BAR_TALL, 1'b0, 11'd0}},
        '{OP_PEAK_RESET, 8'h55, 1'b1, '{7'd100, 8'(127), TREND_UP, HEAT_CALIBRATING,
            COLOR_RED, BAR_TALL, 1'b0, 11'd0}},
        '{OP_READING, 8'(-110), 1'b0, '0},
        '{OP_READING, 8'(-109), 1'b0, '0},
        '{OP_READING, 8'(-102), 1'b0, '0},
        '{OP_READING, 8'(-98), 1'b0, '0},
        '{OP_READING, 8'(-83), 1'b0, '0},
        '{OP_READING, 8'(-82), 1'b0, '0},
        '{OP_READING, 8'(-56), 1'b0, '0},
        '{OP_READING, 8'(-31), 1'b0, '0},
        '{OP_READING, 8'(-30), 1'b0, '0},
        '{OP_READING, 8'(-33), 1'b0, '0},
        '{OP_PEAK_RESET, 8'hAA, 1'b0, '0},
        '{OP_READING, 8'(-70), 1'b0, '0},
        '{OP_READING, 8'(-70), 1'b0, '0},
        '{OP_READING, 8'(-64), 1'b0, '0},
        '{OP_READING, 8'(-58), 1'b0, '0},
        '{OP_READING, 8'(-50), 1'b0, '0},
        '{OP_READING, 8'(-30), 1'b0, '0},
        '{OP_READING, 8'(-75), 1'b0, '0},
        '{OP_READING, 8'(-105), 1'b0, '0},
        '{OP_READING, 8'(-105), 1'b0, '0},
        '{OP_READING, 8'(-40), 1'b0, '0},
        '{OP_PEAK_RESET, 8'h7F, 1'b0, '0}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     operation = OP_READING;
    logic signed [RSSI_W-1:0] rssi_dbm = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [PCT_W-1:0]         strength_pct;
    logic signed [RSSI_W-1:0] peak_dbm;
    logic [1:0]               trend;
    logic [2:0]               heat_class;
    logic [1:0]               color_class;
    logic [1:0]               bar_level;
    logic                     beep_fire;
    logic [FREQ_W-1:0]        beep_freq_hz;

    logic quiet = 1'b0;
    logic hold_flip = 1'b0;
    int   fail_count = 0;

    logic signed [RSSI_W-1:0] prev_dbm;
    logic signed [RSSI_W-1:0] cur_dbm;
    logic signed [RSSI_W-1:0] peak_hold;
    logic signed [RSSI_W-1:0] base_dbm;
    logic                     base_set;
    logic [CNT_W-1:0]         reading_cnt;
    logic [CNT_W-1:0]         beep_cnt;
    logic                     cfg_audio;
    logic [CNT_W-1:0]         cfg_wait;

    readout_t readout_buf [TRACK_DEPTH];
    int       readout_wr = 0;
    int       readout_rd = 0;
    step_t    known_buf [TRACK_DEPTH];
    int       known_wr = 0;
    int       known_rd = 0;

    rssi_proximity_indicator_core #(
        .RSSI_BITS(RSSI_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .rssi_dbm(rssi_dbm),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .strength_pct(strength_pct),
        .peak_dbm(peak_dbm),
        .trend(trend),
        .heat_class(heat_class),
        .color_class(color_class),
        .bar_level(bar_level),
        .beep_fire(beep_fire),
        .beep_freq_hz(beep_freq_hz)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500000;
        $display("tb_rssi_proximity_indicator_core NOT OK");
        $finish;
    end

    function automatic readout_t predict_readout(input logic op,
                                                 input logic signed [RSSI_W-1:0] dbm);
        readout_t         r;
        int               pct;
        int               delta;
        int               above;
        logic [CNT_W-1:0] interval;
        r = '0;
        if (op == OP_PEAK_RESET)
        begin
            peak_hold = cur_dbm;
            base_set = 1'b0;
        end
        else
        begin
            prev_dbm = cur_dbm;
            cur_dbm = dbm;
            if (reading_cnt != COUNT_MAX)
                reading_cnt = reading_cnt + 1'b1;
            if (!base_set && reading_cnt >= cfg_wait)
            begin
                base_dbm = cur_dbm;
                base_set = 1'b1;
            end
            if (cur_dbm > peak_hold)
                peak_hold = cur_dbm;
        end

        if (cur_dbm <= RSSI_FLOOR_DBM)
            pct = 0;
        else if (cur_dbm >= RSSI_CEIL_DBM)
            pct = 100;
        else
            pct = (int'(cur_dbm) - RSSI_FLOOR_DBM) * 100 / (RSSI_CEIL_DBM - RSSI_FLOOR_DBM);

        if (op == OP_READING && cfg_audio && base_set)
        begin
            if (pct >= 80)
                interval = BEEP_EVERY_1;
            else if (pct >= 50)
                interval = BEEP_EVERY_2;
            else if (pct >= 20)
                interval = BEEP_EVERY_5;
            else
                interval = BEEP_EVERY_10;
            beep_cnt = beep_cnt + 1'b1;
            if (beep_cnt >= interval)
            begin
                beep_cnt = '0;
                r.beep_fire = 1'b1;
                r.beep_freq_hz = TONE_BASE_HZ + TONE_STEP_HZ * FREQ_W'(pct);
            end
        end

        delta = int'(cur_dbm) - int'(prev_dbm);
        if (delta > TREND_STEP)
            r.trend = TREND_UP;
        else if (delta < -TREND_STEP)
            r.trend = TREND_DOWN;
        else
            r.trend = TREND_STEADY;

        above = int'(cur_dbm) - int'(base_dbm);
        if (!base_set)
            r.heat_class = HEAT_CALIBRATING;
        else if (above >= HEAT_HOT)
            r.heat_class = HEAT_HOT_CLASS;
        else if (above >= HEAT_WARM)
            r.heat_class = HEAT_WARM_CLASS;
        else if (above >= HEAT_NEAR)
            r.heat_class = HEAT_NEAR_CLASS;
        else if (above >= 0)
            r.heat_class = HEAT_COOL_CLASS;
        else
            r.heat_class = HEAT_COLD_CLASS;

        if (pct >= 75)
            r.color_class = COLOR_RED;
        else if (pct >= 50)
            r.color_class = COLOR_YELLOW;
        else if (pct >= 25)
            r.color_class = COLOR_GREEN;
        else
            r.color_class = COLOR_GREY;

        if (pct >= 67)
            r.bar_level = BAR_TALL;
        else if (pct >= 34)
            r.bar_level = BAR_MID;
        else if (pct >= 10)
            r.bar_level = BAR_LOW;
        else
            r.bar_level = BAR_BLANK;

        r.strength_pct = PCT_W'(pct);
        r.peak_dbm = peak_hold;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        readout_t e;
        step_t    row;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (readout_wr == readout_rd)
                begin
                    $error("result beat with no expected readout pending");
                    fail_count++;
                end
                else
                begin
                    e = readout_buf[readout_rd % TRACK_DEPTH];
                    readout_rd++;
                    check_field("strength_pct", int'(e.strength_pct), int'(strength_pct));
                    check_field("peak_dbm", int'($signed(e.peak_dbm)), int'(peak_dbm));
                    check_field("trend", int'(e.trend), int'(trend));
                    check_field("heat_class", int'(e.heat_class), int'(heat_class));
                    check_field("color_class", int'(e.color_class), int'(color_class));
                    check_field("bar_level", int'(e.bar_level), int'(bar_level));
                    check_field("beep_fire", int'(e.beep_fire), int'(beep_fire));
                    check_field("beep_freq_hz", int'(e.beep_freq_hz), int'(beep_freq_hz));
                end
            end
            if (in_valid && !in_stall)
            begin
                e = predict_readout(operation, rssi_dbm);
                row = known_buf[known_rd % TRACK_DEPTH];
                known_rd++;
                if (row.typed)
                    e = row.want;
                readout_buf[readout_wr % TRACK_DEPTH] = e;
                readout_wr++;
            end
        end
    end

    // The receiver stalls at random unless quiet is set, and holds off for a long stretch whenever
    // hold_flip toggles so that the block backs up into its input.
    initial
    begin : receiver
        int   held;
        logic seen_flip;
        held = 0;
        seen_flip = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_flip != seen_flip)
            begin
                seen_flip = hold_flip;
                held = HOLD_CYCLES;
            end
            if (held > 0)
            begin
                held--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 26);
        end
    end

    task automatic offer_beat(input step_t s);
        int gap;
        gap = 0;
        while (!quiet && $urandom_range(99) < 26)
            gap++;
        known_buf[known_wr % TRACK_DEPTH] = s;
        known_wr++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= s.op;
        rssi_dbm <= s.dbm;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (readout_wr != readout_rd);
    endtask

    task automatic write_config(input logic aud, input logic [CNT_W-1:0] wt);
        logic [DATA_W-1:0] data;
        logic              reg_idx;
        int                k;
        for (k = 0; k < 2; k++)
        begin
            reg_idx = (k == 0) ? REG_AUDIO_ENABLE : REG_BASELINE_WAIT;
            data = $urandom();
            if (reg_idx == REG_AUDIO_ENABLE)
                data[0] = aud;
            else
                data[CNT_W-1:0] = wt;
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {reg_idx, 2'b00};
            pwdata <= data;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_audio = aud;
        cfg_wait = wt;
    endtask

    initial
    begin : stimulus
        int               i;
        int               n;
        int               pick;
        int               walk;
        int               phase;
        step_t            s;
        logic             aud;
        logic [CNT_W-1:0] wt;

        prev_dbm = '0;
        cur_dbm = '0;
        peak_hold = {1'b1, {(RSSI_W-1){1'b0}}};
        base_dbm = '0;
        base_set = 1'b0;
        reading_cnt = '0;
        beep_cnt = '0;
        cfg_audio = 1'b0;
        cfg_wait = BASELINE_WAIT_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (i == AUDIO_ROW)
            begin
                wait_idle();
                write_config(1'b1, 4'd0);
            end
            offer_beat(DIRECTED_STEPS[i]);
        end

        walk = -70;
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    aud = 1'b1;
                    wt = 4'd15;
                end
                1:
                begin
                    aud = 1'b1;
                    wt = 4'd1;
                end
                2:
                begin
                    aud = 1'b0;
                    wt = 4'd0;
                end
                3:
                begin
                    aud = 1'b1;
                    wt = 4'd7;
                end
                default:
                begin
                    aud = 1'($urandom_range(1));
                    wt = 4'($urandom_range(15));
                end
            endcase
            write_config(aud, wt);
            if (phase == PRESSURE_PHASE)
            begin
                quiet <= 1'b1;
                hold_flip <= ~hold_flip;
            end
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                pick = $urandom_range(99);
                s = '0;
                if (pick < 6)
                begin
                    s.op = OP_PEAK_RESET;
                    s.dbm = 8'($urandom);
                end
                else if (pick < 16)
                begin
                    s.op = OP_READING;
                    s.dbm = 8'($urandom);
                end
                else
                begin
                    walk = walk + int'($urandom_range(16)) - 8;
                    if (walk < -125)
                        walk = -125;
                    if (walk > -20)
                        walk = -20;
                    s.op = OP_READING;
                    s.dbm = 8'(walk);
                end
                offer_beat(s);
            end
            quiet <= 1'b0;
        end

        wait_idle();
        repeat (6) @(posedge clk);
        if (fail_count == 0 && readout_wr == readout_rd)
            $display("tb_rssi_proximity_indicator_core OK");
        else
            $display("tb_rssi_proximity_indicator_core NOT OK");
        $finish;
    end

endmodule
